[rtl/core/snr_oversubtraction_factor_assert.svh]
// assertion macros for the snr oversubtraction factor block
// used by the port checker; no other dependencies
`ifndef SNR_OVERSUBTRACTION_FACTOR_ASSERT_SVH
`define SNR_OVERSUBTRACTION_FACTOR_ASSERT_SVH

// checked only out of reset
`define SOF_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sof assertion failed");

// checked at every edge, reset included
`define SOF_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("sof assertion failed");

`endif

[rtl/core/sof_pkg.sv]
// types, constants and the log2 fraction table function of the snr factor block
// no dependencies
`default_nettype none

package sof_pkg;

  localparam int unsigned PWR_W   = 32;
  localparam int unsigned FAC_W   = 16;
  localparam int unsigned ADDR_W  = 5;

  localparam logic [2:0] REG_STRENGTH   = 3'd0;
  localparam logic [2:0] REG_FACTOR_MIN = 3'd1;
  localparam logic [2:0] REG_FACTOR_MAX = 3'd2;
  localparam logic [2:0] REG_SNR_LOW    = 3'd3;
  localparam logic [2:0] REG_SNR_HIGH   = 3'd4;
  localparam logic [2:0] REG_NOISE_EPS  = 3'd5;

  localparam logic [16:0] STRENGTH_RST   = 17'd32768;
  localparam logic [16:0] STRENGTH_MAX   = 17'd65536;
  localparam logic [15:0] FACTOR_MIN_RST = 16'd4096;
  localparam logic [15:0] FACTOR_MAX_RST = 16'd16384;
  localparam logic [15:0] SNR_LOW_RST    = 16'd0;
  localparam logic [15:0] SNR_HIGH_RST   = 16'd5120;
  localparam logic [15:0] NOISE_EPS_RST  = 16'd1;

  // 10*log10(2) in q.16
  localparam logic [17:0] DB_PER_OCTAVE = 18'd197283;

  localparam logic [1:0] SEL_PEAK   = 2'd0;
  localparam logic [1:0] SEL_MIN    = 2'd1;
  localparam logic [1:0] SEL_INTERP = 2'd2;

  typedef struct packed {
    logic       last;
    logic [1:0] sel;
    logic       neg;
  } sof_side_t;

  // log2(1 + i/2^b) in q0.16, bit by bit through repeated squaring
  function automatic logic [15:0] frac_entry(input int unsigned i, input int unsigned b);
    logic [63:0] x;
    logic [15:0] r;
    x = (64'(64'd1 << b) + 64'(i)) << (31 - b);
    r = '0;
    for (int k = 0; k < 16; k++) begin
      x = (x * x) >> 31;
      r = {r[14:0], 1'b0};
      if (x >= 64'h1_0000_0000) begin
        r[0] = 1'b1;
        x = x >> 1;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/sof_if.sv]
// valid/ready channel interfaces for bins in and factors out
// no dependencies
`default_nettype none

interface sof_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] ref_power;
  logic [31:0] noise_power;
  logic        last_bin;
  modport source (output valid, ref_power, noise_power, last_bin, input ready);
  modport sink   (input valid, ref_power, noise_power, last_bin, output ready);
endinterface

interface sof_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] factor;
  logic        last_out;
  modport source (output valid, factor, last_out, input ready);
  modport sink   (input valid, factor, last_out, output ready);
endinterface

`default_nettype wire

[rtl/core/snr_oversubtraction_factor.sv]
// snr dependent oversubtraction factor, one spectral bin per cycle
// depends on sof_pkg and the channel interfaces in sof_if.sv
//
// in_ch carries one bin per transaction: reference power, noise power and the
// last-bin flag. out_ch returns one transaction per bin: the q4.12 factor and a
// copy of the flag, in input order. registers sit on an apb port (psel..prdata)
// at byte addresses 0,4,..,20; the user must write them only while no bin is in
// flight, and the block does not enforce this. the bin runs through a 25 stage
// pipeline: input capture, leading one search, table index, log2 difference, db
// scaling, snr rounding, threshold compare, one multiply, sixteen one-bit
// stages of the restoring divider and the output register. throughput is one
// bin per cycle; the divider stages set the depth. all stages move together:
// when out_ch holds a transaction that is not taken, the whole pipeline and
// in_ch.ready stall and nothing is lost or repeated. a synchronous reset empties
// the pipeline and restores the register defaults; no clearing pass is needed.
`default_nettype none

module snr_oversubtraction_factor
  import sof_pkg::*;
#(
  parameter int unsigned LOG_TABLE_BITS = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  sof_in_if.sink                   in_ch,
  sof_out_if.source                out_ch,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ADDR_W-1:0]   paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready
);

  localparam int unsigned TBL_SIZE = 1 << LOG_TABLE_BITS;
  localparam int unsigned DIV_N    = 16;

  logic [15:0] frac_tbl [TBL_SIZE];
  for (genvar g = 0; g < TBL_SIZE; g++) begin : g_tbl
    assign frac_tbl[g] = frac_entry(g, LOG_TABLE_BITS);
  end

  // configuration
  logic [16:0] strength_r;
  logic [15:0] fmin_r, fmax_r, low_r, high_r, eps_r;
  logic        wr_en;
  logic [2:0]  wr_idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wr_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strength_r <= STRENGTH_RST;
      fmin_r     <= FACTOR_MIN_RST;
      fmax_r     <= FACTOR_MAX_RST;
      low_r      <= SNR_LOW_RST;
      high_r     <= SNR_HIGH_RST;
      eps_r      <= NOISE_EPS_RST;
    end else if (wr_en) begin
      case (wr_idx)
        REG_STRENGTH:   strength_r <= pwdata[16:0];
        REG_FACTOR_MIN: fmin_r     <= pwdata[15:0];
        REG_FACTOR_MAX: fmax_r     <= pwdata[15:0];
        REG_SNR_LOW:    low_r      <= pwdata[15:0];
        REG_SNR_HIGH:   high_r     <= pwdata[15:0];
        REG_NOISE_EPS:  eps_r      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (wr_idx)
      REG_STRENGTH:   prdata = {15'd0, strength_r};
      REG_FACTOR_MIN: prdata = {16'd0, fmin_r};
      REG_FACTOR_MAX: prdata = {16'd0, fmax_r};
      REG_SNR_LOW:    prdata = {16'd0, low_r};
      REG_SNR_HIGH:   prdata = {16'd0, high_r};
      REG_NOISE_EPS:  prdata = {16'd0, eps_r};
      default:        prdata = '0;
    endcase
  end

  // peak factor from the registers
  logic        [16:0] st_sat;
  logic signed [34:0] pk_prod;
  logic signed [34:0] pk_q;
  logic signed [17:0] peak_nxt;
  logic        [15:0] peak_r;
  logic signed [16:0] rng_r;

  always_comb begin
    st_sat  = (strength_r > STRENGTH_MAX) ? STRENGTH_MAX : strength_r;
    pk_prod = 35'($signed({1'b0, st_sat}) * ($signed({1'b0, fmax_r}) - $signed({1'b0, fmin_r})));
    pk_q    = pk_prod[34] ? ((pk_prod + 35'sd65535) >>> 16) : (pk_prod >>> 16);
    peak_nxt = $signed({2'b00, fmin_r}) + 18'(pk_q);
  end

  always_ff @(posedge clk) begin
    peak_r <= peak_nxt[15:0];
    rng_r  <= $signed({1'b0, peak_r}) - $signed({1'b0, fmin_r});
  end

  // pipeline
  logic en;
  logic out_vld_r;
  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r;
  logic l1_r, l2_r, l3_r, l4_r, l5_r, l6_r, l7_r;
  logic [32:0] ref1_r, den1_r, ref2_r, den2_r;
  logic [33:0] den_sum;
  logic [5:0]  pr_nxt, pd_nxt, pr2_r, pd2_r;
  logic        z2_r, z3_r, z4_r, z5_r, z6_r;
  logic [32:0] nr, nd;
  logic [LOG_TABLE_BITS-1:0] ir3_r, id3_r;
  logic [5:0]  pr3_r, pd3_r;
  logic signed [23:0] l4_val_r;
  logic [22:0] labs;
  logic [40:0] mag5_r;
  logic        neg5_r;
  logic [41:0] q_sum;
  logic [17:0] q_raw;
  logic [16:0] q_sat;
  logic signed [15:0] snr_nxt, snr6_r;
  logic signed [16:0] diff_full, d_full;
  logic [1:0]  sel_nxt;
  logic [1:0]  sel7_r;
  logic [15:0] diff7_r, d7_r;
  logic [16:0] rng_abs;
  logic [31:0] num8_r;
  logic [15:0] d8_r;
  sof_side_t   side8_r;

  assign den_sum = 34'(in_ch.noise_power) + 34'(eps_r);

  always_comb begin
    pr_nxt = '0;
    pd_nxt = '0;
    for (int i = 0; i < 33; i++) begin
      if (ref1_r[i]) pr_nxt = 6'(i);
      if (den1_r[i]) pd_nxt = 6'(i);
    end
    nr = ref2_r << (6'd32 - pr2_r);
    nd = den2_r << (6'd32 - pd2_r);
    labs = l4_val_r[23] ? 23'(-l4_val_r) : l4_val_r[22:0];
    q_sum = 42'(mag5_r) + 42'(24'h80_0000);
    q_raw = q_sum[41:24];
    q_sat = (q_raw > 18'd32768) ? 17'd32768 : q_raw[16:0];
    if (neg5_r) snr_nxt = 16'(-$signed({1'b0, q_sat}));
    else        snr_nxt = (q_sat > 17'd32767) ? 16'sd32767 : $signed(q_sat[15:0]);
    diff_full = 17'(snr6_r) - 17'($signed(low_r));
    d_full    = 17'($signed(high_r)) - 17'($signed(low_r));
    if (z6_r || snr6_r <= $signed(low_r)) sel_nxt = SEL_PEAK;
    else if (snr6_r >= $signed(high_r))   sel_nxt = SEL_MIN;
    else                                  sel_nxt = SEL_INTERP;
    rng_abs = rng_r[16] ? 17'(-rng_r) : rng_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      {v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r} <= '0;
    end else if (en) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ref1_r   <= {1'b0, in_ch.ref_power};
      den1_r   <= (den_sum[32:0] == '0) ? 33'd1 : den_sum[32:0];
      l1_r     <= in_ch.last_bin;
      ref2_r   <= ref1_r;
      den2_r   <= den1_r;
      pr2_r    <= pr_nxt;
      pd2_r    <= pd_nxt;
      z2_r     <= (ref1_r == '0);
      l2_r     <= l1_r;
      ir3_r    <= nr[31 -: LOG_TABLE_BITS];
      id3_r    <= nd[31 -: LOG_TABLE_BITS];
      pr3_r    <= pr2_r;
      pd3_r    <= pd2_r;
      z3_r     <= z2_r;
      l3_r     <= l2_r;
      l4_val_r <= $signed({2'b00, pr3_r, 16'h0}) - $signed({2'b00, pd3_r, 16'h0})
                + $signed({8'h0, frac_tbl[ir3_r]}) - $signed({8'h0, frac_tbl[id3_r]});
      z4_r     <= z3_r;
      l4_r     <= l3_r;
      mag5_r   <= 41'(labs) * 41'(DB_PER_OCTAVE);
      neg5_r   <= l4_val_r[23];
      z5_r     <= z4_r;
      l5_r     <= l4_r;
      snr6_r   <= snr_nxt;
      z6_r     <= z5_r;
      l6_r     <= l5_r;
      sel7_r   <= sel_nxt;
      diff7_r  <= diff_full[15:0];
      d7_r     <= d_full[15:0];
      l7_r     <= l6_r;
      num8_r   <= 32'(diff7_r) * 32'(rng_abs[15:0]);
      d8_r     <= d7_r;
      side8_r  <= '{last: l7_r, sel: sel7_r, neg: rng_r[16]};
    end
  end

  // restoring divider, one quotient bit per stage
  logic              dv_vld_r  [DIV_N+1];
  logic [31:0]       dv_rem_r  [DIV_N+1];
  logic [15:0]       dv_q_r    [DIV_N+1];
  logic [15:0]       dv_d_r    [DIV_N+1];
  sof_side_t         dv_side_r [DIV_N+1];

  always_comb begin
    dv_vld_r[0]  = v8_r;
    dv_rem_r[0]  = num8_r;
    dv_q_r[0]    = '0;
    dv_d_r[0]    = d8_r;
    dv_side_r[0] = side8_r;
  end

  for (genvar g = 0; g < DIV_N; g++) begin : g_div
    localparam int unsigned K = DIV_N - 1 - g;
    logic [47:0] shd;
    logic        take;
    assign shd  = 48'(dv_d_r[g]) << K;
    assign take = (48'(dv_rem_r[g]) >= shd);

    always_ff @(posedge clk) begin
      if (!rst_n) dv_vld_r[g+1] <= 1'b0;
      else if (en) dv_vld_r[g+1] <= dv_vld_r[g];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem_r[g+1]  <= take ? 32'(48'(dv_rem_r[g]) - shd) : dv_rem_r[g];
        dv_q_r[g+1]    <= dv_q_r[g] | (take ? 16'(16'd1 << K) : 16'd0);
        dv_d_r[g+1]    <= dv_d_r[g];
        dv_side_r[g+1] <= dv_side_r[g];
      end
    end
  end

  // final select and clamp
  sof_side_t          fs;
  logic signed [17:0] fac_i;
  logic        [15:0] fac_nxt;
  logic        [15:0] fac_r;
  logic               last_r;

  always_comb begin
    fs = dv_side_r[DIV_N];
    if (fs.neg) fac_i = $signed({2'b00, peak_r}) + $signed({2'b00, dv_q_r[DIV_N]});
    else        fac_i = $signed({2'b00, peak_r}) - $signed({2'b00, dv_q_r[DIV_N]});
    case (fs.sel)
      SEL_PEAK:   fac_nxt = peak_r;
      SEL_MIN:    fac_nxt = fmin_r;
      SEL_INTERP: begin
        if (fac_i < 0)                 fac_nxt = '0;
        else if (fac_i > 18'sd65535)   fac_nxt = 16'hFFFF;
        else                           fac_nxt = fac_i[15:0];
      end
      default:    fac_nxt = peak_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (en) out_vld_r <= dv_vld_r[DIV_N];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fac_r  <= fac_nxt;
      last_r <= fs.last;
    end
  end

  assign out_ch.valid    = out_vld_r;
  assign out_ch.factor   = fac_r;
  assign out_ch.last_out = last_r;

endmodule

`default_nettype wire

[rtl/core/sof_checker.sv]
// port checker for the snr factor block and its bind to the top level
// depends on snr_oversubtraction_factor_assert.svh
`default_nettype none

`include "snr_oversubtraction_factor_assert.svh"

module sof_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_factor,
  input wire logic        out_last
);

  `SOF_ASSERT_ALWAYS(a_empty_after_reset, clk, !rst_n |=> !out_valid)
  `SOF_ASSERT(a_ready_tracks_out, clk, rst_n, in_ready == (!out_valid || out_ready))
  `SOF_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_factor) && $stable(out_last))

endmodule

bind snr_oversubtraction_factor sof_checker u_sof_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_factor (out_ch.factor),
  .out_last   (out_ch.last_out)
);

`default_nettype wire

[tb/tb.sv]
// testbench for snr_oversubtraction_factor: random and directed bins against a
// scoreboard that predicts the q4.12 factor; depends on sof_pkg and sof_if.sv
`timescale 1ns / 1ps

module tb
  import sof_pkg::*;
;

  typedef struct {
    logic [15:0] factor;
    logic        last;
  } factor_exp_t;

  class factor_scoreboard;
    logic [15:0] log_frac[256];
    logic [16:0] strength;
    logic [15:0] fmin, fmax, eps;
    logic signed [15:0] low_db, high_db;
    factor_exp_t pending_q[$];
    int unsigned n_bins, n_checked;

    function new();
      logic [63:0] x;
      logic [15:0] r;
      for (int i = 0; i < 256; i++) begin
        x = (64'd256 + 64'(i)) << 23;
        r = '0;
        for (int k = 0; k < 16; k++) begin
          x = (x * x) >> 31;
          r = {r[14:0], 1'b0};
          if (x >= 64'h1_0000_0000) begin
            r[0] = 1'b1;
            x = x >> 1;
          end
        end
        log_frac[i] = r;
      end
      strength = STRENGTH_RST;
      fmin = FACTOR_MIN_RST;
      fmax = FACTOR_MAX_RST;
      low_db = SNR_LOW_RST;
      high_db = SNR_HIGH_RST;
      eps = NOISE_EPS_RST;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        REG_STRENGTH:   strength = v[16:0];
        REG_FACTOR_MIN: fmin = v[15:0];
        REG_FACTOR_MAX: fmax = v[15:0];
        REG_SNR_LOW:    low_db = v[15:0];
        REG_SNR_HIGH:   high_db = v[15:0];
        REG_NOISE_EPS:  eps = v[15:0];
        default: ;
      endcase
    endfunction

    function longint log2_q16(logic [63:0] x);
      int p;
      logic [63:0] idx;
      p = 0;
      while (p < 63 && (x >> (p + 1)) != 0) p++;
      if (p >= 8) idx = (x >> (p - 8)) & 64'd255;
      else idx = (x << (8 - p)) & 64'd255;
      return longint'(p) * 65536 + longint'(log_frac[idx[7:0]]);
    endfunction

    function void note_bin(logic [31:0] ref_pwr, logic [31:0] noise_pwr, logic last);
      logic [63:0] den, mag, q;
      longint st, lo, pk, fac, l, snr;
      factor_exp_t e;
      den = 64'(noise_pwr) + 64'(eps);
      st = (strength > STRENGTH_MAX) ? 65536 : longint'(strength);
      lo = longint'(fmin);
      pk = lo + (st * (longint'(fmax) - lo)) / 65536;
      if (ref_pwr == 0) fac = pk;
      else begin
        if (den == 0) den = 1;
        l = log2_q16(64'(ref_pwr)) - log2_q16(den);
        mag = 64'(l < 0 ? -l : l) * 64'd197283;
        q = (mag + (64'd1 << 23)) >> 24;
        if (q > 32768) q = 32768;
        snr = l < 0 ? -longint'(q) : longint'(q);
        if (snr > 32767) snr = 32767;
        if (snr <= longint'(low_db)) fac = pk;
        else if (snr >= longint'(high_db)) fac = lo;
        else fac = pk - ((snr - longint'(low_db)) * (pk - lo)) /
                        (longint'(high_db) - longint'(low_db));
      end
      if (fac < 0) fac = 0;
      if (fac > 65535) fac = 65535;
      e.factor = fac[15:0];
      e.last = last;
      pending_q.push_back(e);
      n_bins++;
    endfunction

    function string check_factor(logic [15:0] factor, logic last);
      factor_exp_t e;
      if (pending_q.size() == 0) return "result with no bin pending";
      e = pending_q.pop_front();
      n_checked++;
      if (factor !== e.factor)
        return $sformatf("factor %0d, expected %0d", factor, e.factor);
      if (last !== e.last)
        return $sformatf("last_out %0b, expected %0b", last, e.last);
      return "";
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int unsigned idle_pct = 0, stall_pct = 0, n_errors = 0;
  factor_scoreboard sb;

  sof_in_if in_ch();
  sof_out_if out_ch();

  snr_oversubtraction_factor u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.ref_power = '0;
    in_ch.noise_power = '0;
    in_ch.last_bin = 1'b0;
    out_ch.ready = 1'b0;
  end

  initial begin
    #20ms;
    $display("tb: FAIL");
    $finish;
  end

  task automatic report_mismatch(string msg);
    n_errors++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  always @(negedge clk) out_ch.ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    string msg;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      msg = sb.check_factor(out_ch.factor, out_ch.last_out);
      if (msg != "") report_mismatch(msg);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, v);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic send_bin(logic [31:0] ref_pwr, logic [31:0] noise_pwr, logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.ref_power = ref_pwr;
    in_ch.noise_power = noise_pwr;
    in_ch.last_bin = last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_bin(ref_pwr, noise_pwr, last);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_power();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(16);
      default: return $urandom >> $urandom_range(31);
    endcase
  endfunction

  task automatic write_all(logic [31:0] st, logic [31:0] lo, logic [31:0] hi,
                           logic [31:0] snr_lo, logic [31:0] snr_hi, logic [31:0] e);
    write_reg(REG_STRENGTH, st);
    write_reg(REG_FACTOR_MIN, lo);
    write_reg(REG_FACTOR_MAX, hi);
    write_reg(REG_SNR_LOW, snr_lo);
    write_reg(REG_SNR_HIGH, snr_hi);
    write_reg(REG_NOISE_EPS, e);
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed bins at reset settings
    send_bin(32'd0, 32'd5, 1'b0);
    send_bin(32'hFFFF_FFFF, 32'd0, 1'b1);
    send_bin(32'd1, 32'hFFFF_FFFF, 1'b0);
    send_bin(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_bin(32'd1000, 32'd99, 1'b0);
    send_bin(32'd100, 32'd3, 1'b0);
    send_bin(32'd7, 32'd6, 1'b1);
    drain();
    // zero eps with zero noise, strength above range, crossed thresholds
    write_all(32'h1FFFF, 32'd0, 32'd65535, 32'd2000, 32'd1000, 32'd0);
    send_bin(32'd50, 32'd0, 1'b0);
    send_bin(32'd0, 32'd0, 1'b1);
    send_bin(32'd500000, 32'd10, 1'b0);
    send_bin(32'd1500, 32'd9, 1'b0);
    send_bin(32'd3, 32'd9, 1'b1);
    drain();
    write_all(32'd0, 32'd65535, 32'd0, 32'hFFFF_8000, 32'd32767, 32'd65535);
    send_bin(32'd12345, 32'd0, 1'b0);
    send_bin(32'hFFFF_FFFF, 32'd0, 1'b1);
    send_bin(32'd1, 32'hFFFF_FFFF, 1'b0);
    drain();
    write_all(32'd65536, 32'd100, 32'd60000, 32'hFFFF_EC00, 32'd2560, 32'd1);
    send_bin(32'd1, 32'd1, 1'b0);
    send_bin(32'd1000, 32'd999, 1'b1);
    send_bin(32'd999, 32'd1000, 1'b0);

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 86; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 86; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      if (ph % 3 == 2)
        write_all($urandom_range(131071), $urandom_range(65535), $urandom_range(65535),
                  $urandom, $urandom, $urandom_range(65535));
      else
        write_all($urandom_range(65536), $urandom_range(8192), $urandom_range(65535),
                  $urandom_range(8000) - 6000, $urandom_range(12000) - 2000,
                  $urandom_range(65535, 1));
      for (int n = 0; n < 250; n++) begin
        if (ph == 3 && n == 125)
          while (sb.pending_q.size() != 0) begin
            in_ch.valid = 1'b0;
            @(negedge clk);
          end
        send_bin(rand_power(), rand_power(), $urandom_range(1));
      end
    end
    drain();
    $display("bins sent %0d, factors checked %0d, over 12 register settings",
             sb.n_bins, sb.n_checked);
    $display("idle and stall mixes covered, including a full drain mid-stream");
    if (n_errors == 0 && sb.pending_q.size() == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end
endmodule
